// ===== src/assert_macros.svh =====
// Assertion helpers used by lpfc_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LPFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lpfc assertion failed");

// Check that a condition implies a property on the same edge.
`define LPFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpfc implication failed");

// Check that a condition implies a property on the next edge.
`define LPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpfc next-cycle check failed");

`endif

// ===== src/lpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfc_pkg: shared constants, types and helpers
// Sizes, payload types and ring address arithmetic for the LRU fault counter.
// ----------------------------------------------------------------------------
package lpfc_pkg;

  localparam int MAX_FRAMES = 128;
  localparam int PAGE_BITS  = 32;
  localparam int CAP_W      = 8;
  localparam int FAULT_W    = 16;
  localparam int FRAME_AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OCC_W      = $clog2(MAX_FRAMES + 1);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_AW-1:0]  frame_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [FAULT_W-1:0]   fault_t;

  localparam fault_t FAULT_MAX = '1;

  // Request handed from the top level to the sequencer
  typedef struct packed {
    logic  valid;
    page_t page;
    logic  new_seq;
  } req_t;

  // Finished result handed back to the top level
  typedef struct packed {
    logic   valid;
    logic   hit;
    fault_t fault_count;
  } done_t;

  // Memory command from the sequencer
  typedef struct packed {
    logic   we;
    frame_t waddr;
    page_t  wdata;
    frame_t raddr;
  } ram_cmd_t;

  // Map a recency position to a physical slot of the ring
  function automatic frame_t ring_addr(frame_t head, occ_t off);
    logic [OCC_W:0] s;
    s = (OCC_W + 1)'(head) + (OCC_W + 1)'(off);
    if (s >= (OCC_W + 1)'(MAX_FRAMES)) begin
      s = s - (OCC_W + 1)'(MAX_FRAMES);
    end
    return frame_t'(s);
  endfunction

  // Clamp the programmed capacity into 1..MAX_FRAMES
  function automatic occ_t eff_cap(logic [CAP_W-1:0] c);
    occ_t r;
    if (c == '0) begin
      r = occ_t'(1);
    end else if (int'(c) > MAX_FRAMES) begin
      r = occ_t'(MAX_FRAMES);
    end else begin
      r = occ_t'(c);
    end
    return r;
  endfunction

endpackage

// ===== src/lpfc_if.sv =====
// ----------------------------------------------------------------------------
// lpfc_if: channel interfaces
// Reference request, result and capacity write channels with valid/ready.
// ----------------------------------------------------------------------------
interface lpfc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_number;
  logic        new_sequence;

  modport source (output valid, page_number, new_sequence, input ready);
  modport sink   (input valid, page_number, new_sequence, output ready);
endinterface

interface lpfc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] fault_count;

  modport source (output valid, hit, fault_count, input ready);
  modport sink   (input valid, hit, fault_count, output ready);
endinterface

interface lpfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ===== src/lpfc_ram.sv =====
// ----------------------------------------------------------------------------
// lpfc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lpfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpfc_ctrl: scan sequencer with shared page comparator
// Walks the recency ring once per request, compares every entry against the
// page, closes the gap behind a hit and places the page at the recent end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpfc_pkg::req_t    req_i,
  output logic              ready_o,
  input  lpfc_pkg::occ_t    cap_i,
  input  logic              out_free_i,
  output lpfc_pkg::done_t   done_o,
  output lpfc_pkg::ram_cmd_t ram_o,
  input  lpfc_pkg::page_t   ram_rdata_i
);
  import lpfc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  frame_t     head_q, head_d;
  occ_t       occ_q, occ_d;
  fault_t     faults_q, faults_d;
  occ_t       pos_q, pos_d;
  occ_t       dpos_q, dpos_d;
  logic       chk_q, chk_d;
  logic       found_q, found_d;
  page_t      page_q, page_d;
  logic       issue;
  logic       match;

  assign issue   = (state_q == ST_SCAN) && (pos_q < occ_q);
  assign match   = chk_q && (ram_rdata_i == page_q);
  assign ready_o = (state_q == ST_IDLE);

  // Sequence the scan, shift and final write
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    occ_d    = occ_q;
    faults_d = faults_q;
    pos_d    = pos_q;
    dpos_d   = dpos_q;
    chk_d    = 1'b0;
    found_d  = found_q;
    page_d   = page_q;
    ram_o    = '0;
    ram_o.raddr = ring_addr(head_q, pos_q);
    done_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          page_d  = req_i.page;
          pos_d   = '0;
          found_d = 1'b0;
          if (req_i.new_seq) begin
            occ_d    = '0;
            faults_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Advance the read pointer
        if (issue) begin
          pos_d  = pos_q + occ_t'(1);
          dpos_d = pos_q;
          chk_d  = 1'b1;
        end
        // Close the gap left by an earlier hit
        if (chk_q && found_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = ring_addr(head_q, dpos_q - occ_t'(1));
          ram_o.wdata = ram_rdata_i;
        end
        found_d = found_q | match;
        if (!issue && !chk_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (out_free_i) begin
          ram_o.we    = 1'b1;
          ram_o.wdata = page_q;
          if (found_q) begin
            ram_o.waddr = ring_addr(head_q, occ_q - occ_t'(1));
          end else begin
            ram_o.waddr = ring_addr(head_q, occ_q);
            if (faults_q != FAULT_MAX) begin
              faults_d = faults_q + fault_t'(1);
            end
            if (occ_q < cap_i) begin
              occ_d = occ_q + occ_t'(1);
            end else begin
              head_d = ring_addr(head_q, occ_t'(1));
            end
          end
          done_o.valid       = 1'b1;
          done_o.hit         = found_q;
          done_o.fault_count = faults_d;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      occ_q    <= '0;
      faults_q <= '0;
      pos_q    <= '0;
      dpos_q   <= '0;
      chk_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      faults_q <= faults_d;
      pos_q    <= pos_d;
      dpos_q   <= dpos_d;
      chk_q    <= chk_d;
      found_q  <= found_d;
    end
  end

  // Page under test
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  `LPFC_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= occ_t'(MAX_FRAMES))
  `LPFC_ASSERT_IMP(a_no_idle_write, clk_i, rst_ni, ram_o.we, state_q != ST_IDLE)
  `LPFC_ASSERT_NEXT(a_fault_step, clk_i, rst_ni, (state_q == ST_FINISH) && out_free_i && !found_q && (faults_q != FAULT_MAX), faults_q == $past(faults_q) + fault_t'(1))

endmodule

// ===== src/lru_page_fault_counter.sv =====
// One request is handled at a time: a new request is taken only once the walk over
// the ring through the single read port and the final write are done.
// A finished result waits in an output register; a new request is taken meanwhile.
// Reset: empty resident set, fault count zero, capacity 4; the RAM is not cleared.
// ----------------------------------------------------------------------------
// lru_page_fault_counter: LRU page replacement fault counter
// Keeps an LRU-ordered ring of resident pages in RAM and reports hit and
// running fault count per page reference.
// ----------------------------------------------------------------------------
module lru_page_fault_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpfc_cfg_if.sink   cfg_i,
  lpfc_req_if.sink   req_i,
  lpfc_rsp_if.source rsp_o
);
  import lpfc_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             rsp_valid_q;
  logic             rsp_hit_q;
  fault_t           rsp_fault_q;
  logic             out_free;
  req_t             req;
  done_t            done;
  ram_cmd_t         ram_cmd;
  page_t            ram_rdata;
  logic             ctrl_ready;

  // Capacity register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(4);
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity;
    end
  end

  // Request into the sequencer
  assign req.valid   = req_i.valid && ctrl_ready;
  assign req.page    = page_t'(req_i.page_number);
  assign req.new_seq = req_i.new_sequence;
  assign req_i.ready = ctrl_ready;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  lpfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (ctrl_ready),
    .cap_i       (eff_cap(cap_q)),
    .out_free_i  (out_free),
    .done_o      (done),
    .ram_o       (ram_cmd),
    .ram_rdata_i (ram_rdata)
  );

  lpfc_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_cmd.we),
    .waddr_i (ram_cmd.waddr),
    .wdata_i (ram_cmd.wdata),
    .raddr_i (ram_cmd.raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done.valid) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      rsp_hit_q   <= done.hit;
      rsp_fault_q <= done.fault_count;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.fault_count = rsp_fault_q;

endmodule

// ===== bench/tb_lru_page_fault_counter.sv =====
// ----------------------------------------------------------------------------
// tb_lru_page_fault_counter: self-checking bench for the LRU fault counter
// Streams page references through the request channel, predicts hit and
// running fault count with a queue-based LRU list, and checks every result
// in order. Covers capacity extremes, shrinking the capacity under a full
// set, new-sequence restarts and back-pressure.
// ----------------------------------------------------------------------------
module tb_lru_page_fault_counter;
  import lpfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = MAX_FRAMES + 8;
  localparam int unsigned MAX_PRINTS   = 100;

  typedef struct {
    page_t       page;
    logic        new_seq;
    int unsigned gap;
  } page_request_t;

  typedef struct {
    logic   hit;
    fault_t faults;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;

  lpfc_cfg_if cfg_ch ();
  lpfc_req_if req_ch ();
  lpfc_rsp_if rsp_ch ();

  lru_page_fault_counter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Pending requests, expected lookups and bookkeeping
  page_request_t  pending_refs[$];
  lookup_result_t expected_lookups[$];
  int unsigned    refs_queued;
  int unsigned    results_seen;
  int unsigned    error_count;
  int unsigned    cycle_count;
  int unsigned    idle_max;
  int unsigned    holds_requested;
  int unsigned    holds_served;
  int unsigned    hold_left;
  int unsigned    capacity_writes;

  // LRU predictor state: index 0 is the least recently used page
  page_t       lru_list[$];
  logic [7:0]  lru_capacity;
  fault_t      fault_tally;
  int unsigned hit_tally;
  int unsigned miss_tally;

  // Driver and monitor working state
  page_request_t  cur_request;
  bit             cur_loaded;
  int unsigned    cur_gap;
  int unsigned    rsp_stall;
  lookup_result_t oldest_lookup;

  // Report one mismatch and count it
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("ERROR [cycle %0d] %s", cycle_count, msg);
    end
  endtask

  // Map the programmed capacity to the number of usable frames
  function automatic int unsigned frames_for(input logic [7:0] cap);
    if (cap == 8'd0) begin
      return 1;
    end
    if (int'(cap) > MAX_FRAMES) begin
      return MAX_FRAMES;
    end
    return int'(cap);
  endfunction

  // Apply one page reference to the LRU list and return hit and fault count
  function automatic lookup_result_t predict_lookup(input page_t page, input logic new_seq);
    lookup_result_t res;
    int where;
    int unsigned frames;
    frames = frames_for(lru_capacity);
    if (new_seq) begin
      lru_list.delete();
      fault_tally = '0;
    end
    where = -1;
    foreach (lru_list[i]) begin
      if (where < 0 && lru_list[i] == page) begin
        where = i;
      end
    end
    if (where >= 0) begin
      lru_list.delete(where);
      lru_list.push_back(page);
      res.hit = 1'b1;
      hit_tally++;
    end else begin
      if (fault_tally != FAULT_MAX) begin
        fault_tally++;
      end
      // A shrunken capacity keeps the set size: evict one, insert one
      if (lru_list.size() >= frames) begin
        void'(lru_list.pop_front());
      end
      lru_list.push_back(page);
      res.hit = 1'b0;
      miss_tally++;
    end
    res.faults = fault_tally;
    return res;
  endfunction

  // Queue one page reference with a gap drawn from the current idle setting
  task automatic queue_reference(input page_t page, input logic new_seq);
    page_request_t r;
    r.page    = page;
    r.new_seq = new_seq;
    r.gap     = $urandom_range(0, idle_max);
    pending_refs.push_back(r);
    refs_queued++;
  endtask

  // Hold until every queued request has produced its result
  task automatic wait_for_results();
    while (results_seen < refs_queued) begin
      @(posedge clk_i);
    end
  endtask

  // Write the capacity register once the block is idle
  task automatic write_capacity(input logic [7:0] value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do begin
      @(posedge clk_i);
    end while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    lru_capacity = value;
    capacity_writes++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Request driver: take the next pending reference, idle its gap, offer it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid        <= 1'b0;
      req_ch.page_number  <= '0;
      req_ch.new_sequence <= 1'b0;
      cur_loaded = 1'b0;
      cur_gap    = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_lookups.push_back(predict_lookup(cur_request.page, cur_request.new_seq));
        cur_loaded = 1'b0;
      end
      if (!cur_loaded && pending_refs.size() != 0) begin
        cur_request = pending_refs.pop_front();
        cur_gap     = cur_request.gap;
        cur_loaded  = 1'b1;
      end
      if (cur_loaded && cur_gap == 0) begin
        req_ch.valid        <= 1'b1;
        req_ch.page_number  <= cur_request.page;
        req_ch.new_sequence <= cur_request.new_seq;
      end else begin
        if (cur_loaded) begin
          cur_gap--;
        end
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed from the stimulus process
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // Result monitor: check each result against the oldest expected lookup
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: hit=%0b faults=%0d",
                                    rsp_ch.hit, rsp_ch.fault_count));
        end else begin
          oldest_lookup = expected_lookups.pop_front();
          if (rsp_ch.hit !== oldest_lookup.hit) begin
            report_mismatch($sformatf("result %0d: hit=%0b, predicted %0b",
                                      results_seen, rsp_ch.hit, oldest_lookup.hit));
          end
          if (rsp_ch.fault_count !== oldest_lookup.faults) begin
            report_mismatch($sformatf("result %0d: fault_count=%0d, predicted %0d",
                                      results_seen, rsp_ch.fault_count,
                                      oldest_lookup.faults));
          end
        end
        rsp_stall = $urandom_range(0, idle_max);
      end else if (rsp_stall != 0) begin
        rsp_stall--;
      end
      rsp_ch.ready <= (rsp_stall == 0) && (hold_left == 0);
    end
  end

  // Stimulus: directed cases, then random phases
  initial begin
    page_t       pool[$];
    page_t       pick;
    logic [7:0]  cap_value;
    int unsigned frames;
    int unsigned pool_size;
    int unsigned phase_refs;
    int unsigned roll;

    rst_ni              = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.capacity     = '0;
    req_ch.valid        = 1'b0;
    req_ch.page_number  = '0;
    req_ch.new_sequence = 1'b0;
    rsp_ch.ready        = 1'b0;
    refs_queued     = 0;
    results_seen    = 0;
    error_count     = 0;
    cycle_count     = 0;
    idle_max        = 9;
    holds_requested = 0;
    capacity_writes = 0;
    lru_capacity    = 8'd4;
    fault_tally     = '0;
    hit_tally       = 0;
    miss_tally      = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity of four: extreme pages, hits, eviction, restart
    queue_reference(32'h0000_0000, 1'b0);
    queue_reference(32'hFFFF_FFFF, 1'b0);
    queue_reference(32'h0000_0000, 1'b0);
    queue_reference(32'h5555_5555, 1'b0);
    queue_reference(32'hAAAA_AAAA, 1'b0);
    queue_reference(32'h0000_0000, 1'b0);
    queue_reference(32'h0000_0001, 1'b0);
    queue_reference(32'hFFFF_FFFF, 1'b0);
    queue_reference(32'h5555_5555, 1'b1);

    // Capacity zero behaves as a single frame
    write_capacity(8'd0);
    queue_reference(32'h0000_0007, 1'b0);
    queue_reference(32'h0000_0007, 1'b0);
    queue_reference(32'h0000_0008, 1'b0);
    queue_reference(32'h0000_0007, 1'b0);

    // Fill six frames, then shrink the capacity under the full set
    write_capacity(8'd8);
    queue_reference(32'h0000_0010, 1'b1);
    queue_reference(32'h0000_0011, 1'b0);
    queue_reference(32'h0000_0012, 1'b0);
    queue_reference(32'h0000_0013, 1'b0);
    queue_reference(32'h0000_0014, 1'b0);
    queue_reference(32'h0000_0015, 1'b0);
    write_capacity(8'd3);
    queue_reference(32'h0000_0010, 1'b0);
    queue_reference(32'h0000_0020, 1'b0);
    queue_reference(32'h0000_0021, 1'b0);
    queue_reference(32'h0000_0012, 1'b0);

    // Random phases over capacity settings, with and without idling
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          cap_value = 8'($urandom_range(1, 8));
        end
        1: begin
          cap_value = 8'd128;
        end
        2: begin
          cap_value = 8'd2;
        end
        3: begin
          cap_value = 8'd255;
        end
        4: begin
          cap_value = 8'd0;
        end
        5: begin
          cap_value = 8'($urandom_range(1, 16));
        end
        6: begin
          cap_value = 8'd1;
        end
        7: begin
          cap_value = 8'($urandom_range(0, 255));
        end
        8: begin
          cap_value = 8'($urandom_range(1, 32));
        end
        default: begin
          cap_value = 8'($urandom_range(1, 8));
        end
      endcase
      write_capacity(cap_value);
      idle_max = (phase % 4 == 2) ? 0 : 9;
      // Stall the receiver long enough for the request side to back up
      if (idle_max == 0) begin
        holds_requested++;
      end
      frames    = frames_for(cap_value);
      pool_size = $urandom_range(frames / 2 + 1, frames + frames / 2 + 1);
      pool.delete();
      repeat (pool_size) pool.push_back($urandom);
      phase_refs = (frames >= 64) ? 200 : 110;
      repeat (phase_refs) begin
        roll = $urandom_range(0, 99);
        pick = pool[$urandom_range(0, pool.size() - 1)];
        if (roll < 4) begin
          queue_reference(pick, 1'b1);
        end else if (roll < 12) begin
          queue_reference($urandom, 1'b0);
        end else begin
          queue_reference(pick, 1'b0);
        end
      end
    end

    // Drain and let the block settle before the verdict
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);
    if (expected_lookups.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                expected_lookups.size()));
    end

    $display("Covered %0d page references (%0d hits, %0d misses) over %0d capacity writes,",
             refs_queued, hit_tally, miss_tally, capacity_writes);
    $display("capacities 0/1/2/128/255, shrink-under-load and long stalls, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lpfc_pkg.sv
src/lpfc_if.sv
src/lpfc_ram.sv
src/lpfc_ctrl.sv
src/lru_page_fault_counter.sv
bench/tb_lru_page_fault_counter.sv
